[hw/rtl/pwid_pkg.sv]
// Shared types and constants of the windowed-integral PID unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pwid_pkg;

    // Default sizes of the error window and the difference lag
    localparam int DEF_WINDOW_LEN = 16;
    localparam int DEF_DIFF_LAG   = 4;

    // Field widths
    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 20;
    localparam int SUM_W   = 21;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DRIVE_W = 29;

    // Register reset values and output bound
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd524288;
    localparam int                 DRIVE_MAX   = 134217728;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_GAIN_P  = 2'd0,
        REG_GAIN_I  = 2'd1,
        REG_GAIN_D  = 2'd2,
        REG_I_LIMIT = 2'd3
    } reg_idx_t;

    // Gain settings handed from the register file to the drive pipeline
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
    } gains_t;

    // Terms of one tick entering the drive pipeline
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
    } terms_t;

endpackage

[hw/rtl/pwid_cell.sv]
// One cell of the error history line: holds one sample, passes it on.
// Depends on pwid_pkg for the sample width.
`timescale 1ns / 1ps

module pwid_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              shift_en,
    input  logic signed [pwid_pkg::ERR_W-1:0] d_in,
    output logic signed [pwid_pkg::ERR_W-1:0] q_out
);

    logic signed [pwid_pkg::ERR_W-1:0] sample_reg;
    logic signed [pwid_pkg::ERR_W-1:0] sample_next;

    // Take the neighbor's sample when the line advances
    always_comb begin
        sample_next = shift_en ? d_in : sample_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    assign q_out = sample_reg;

endmodule

[hw/rtl/pwid_regs.sv]
// APB register file of the PID unit: gains and integral limit.
// Depends on pwid_pkg for register indexes and the gains struct.
`timescale 1ns / 1ps

module pwid_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output pwid_pkg::gains_t                    gains,
    output logic [pwid_pkg::LIMIT_W-1:0]        limit
);

    pwid_pkg::gains_t                 gains_reg;
    pwid_pkg::gains_t                 gains_next;
    logic [pwid_pkg::LIMIT_W-1:0]     limit_reg;
    logic [pwid_pkg::LIMIT_W-1:0]     limit_next;
    logic                             wr_en;
    pwid_pkg::reg_idx_t               idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = pwid_pkg::reg_idx_t'(paddr[3:2]);

    // Decode the write word into the addressed register
    always_comb begin
        gains_next = gains_reg;
        limit_next = limit_reg;
        if (wr_en) begin
            case (idx)
                pwid_pkg::REG_GAIN_P:  gains_next.gain_p = pwdata[15:0];
                pwid_pkg::REG_GAIN_I:  gains_next.gain_i = pwdata[15:0];
                pwid_pkg::REG_GAIN_D:  gains_next.gain_d = pwdata[15:0];
                pwid_pkg::REG_I_LIMIT: limit_next = pwdata[pwid_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
            limit_reg <= pwid_pkg::LIMIT_RESET;
        end else begin
            gains_reg <= gains_next;
            limit_reg <= limit_next;
        end
    end

    // Read back the addressed register, zero filled
    always_comb begin
        case (idx)
            pwid_pkg::REG_GAIN_P:  prdata = {16'd0, gains_reg.gain_p};
            pwid_pkg::REG_GAIN_I:  prdata = {16'd0, gains_reg.gain_i};
            pwid_pkg::REG_GAIN_D:  prdata = {16'd0, gains_reg.gain_d};
            pwid_pkg::REG_I_LIMIT: prdata = {12'd0, limit_reg};
            default:               prdata = '0;
        endcase
    end

    assign gains = gains_reg;
    assign limit = limit_reg;

endmodule

[hw/rtl/pwid_drive.sv]
// Three-stage drive pipeline: hold terms, multiply by gains, sum, shift, saturate.
// Depends on pwid_pkg for the terms and gains structs and output bound.
`timescale 1ns / 1ps

module pwid_drive (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pwid_pkg::gains_t                    gains,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pwid_pkg::terms_t                    in_terms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pwid_pkg::DRIVE_W-1:0] out_drive
);

    localparam int PP_W  = pwid_pkg::GAIN_W + pwid_pkg::ERR_W;
    localparam int PI_W  = pwid_pkg::GAIN_W + pwid_pkg::SUM_W;
    localparam int PD_W  = pwid_pkg::GAIN_W + pwid_pkg::DIFF_W;
    localparam int TOT_W = PI_W + 1;
    localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'(pwid_pkg::DRIVE_MAX);
    localparam logic signed [TOT_W-1:0] SAT_LO = -SAT_HI;

    logic                 a_valid_reg, a_valid_next;
    pwid_pkg::terms_t     a_reg, a_next;
    logic                 b_valid_reg, b_valid_next;
    logic signed [PP_W-1:0] prod_p_reg, prod_p_next;
    logic signed [PI_W-1:0] prod_i_reg, prod_i_next;
    logic signed [PD_W-1:0] prod_d_reg, prod_d_next;
    logic                 c_valid_reg, c_valid_next;
    logic signed [pwid_pkg::DRIVE_W-1:0] drive_reg, drive_next;
    logic                 a_adv, b_adv, c_adv;
    logic signed [TOT_W-1:0] total, shifted, sat;

    // Each stage advances when empty or when the one after it moves
    assign c_adv    = !c_valid_reg || out_ready;
    assign b_adv    = !b_valid_reg || c_adv;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;

    // Stage A: hold the terms of the accepted word
    always_comb begin
        a_valid_next = a_adv ? in_valid : a_valid_reg;
        a_next       = (a_adv && in_valid) ? in_terms : a_reg;
    end

    // Stage B: one multiplier per term
    always_comb begin
        b_valid_next = b_adv ? a_valid_reg : b_valid_reg;
        prod_p_next  = prod_p_reg;
        prod_i_next  = prod_i_reg;
        prod_d_next  = prod_d_reg;
        if (b_adv && a_valid_reg) begin
            prod_p_next = PP_W'(gains.gain_p) * PP_W'(a_reg.err);
            prod_i_next = PI_W'(gains.gain_i) * PI_W'(a_reg.sum);
            prod_d_next = PD_W'(gains.gain_d) * PD_W'(a_reg.diff);
        end
    end

    // Stage C: add, drop the Q8 fraction toward minus infinity, saturate
    always_comb begin
        total   = TOT_W'(prod_p_reg) + TOT_W'(prod_i_reg) + TOT_W'(prod_d_reg);
        shifted = total >>> 8;
        if (shifted > SAT_HI) begin
            sat = SAT_HI;
        end else if (shifted < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = shifted;
        end
        c_valid_next = c_adv ? b_valid_reg : c_valid_reg;
        drive_next   = (c_adv && b_valid_reg) ? pwid_pkg::DRIVE_W'(sat) : drive_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        prod_p_reg <= prod_p_next;
        prod_i_reg <= prod_i_next;
        prod_d_reg <= prod_d_next;
        drive_reg  <= drive_next;
    end

    assign out_valid = c_valid_reg;
    assign out_drive = drive_reg;

    // A full stage moves on into a free successor; an empty stage A keeps the input ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && b_adv |=> b_valid_reg)
        else $error("stage B lost a word");
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && c_adv |=> c_valid_reg)
        else $error("stage C lost a word");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |-> in_ready)
        else $error("input stalled with stage A empty");

endmodule

[hw/rtl/pid_windowed_integral_lagged_diff_unit.sv]
// Top level of the windowed-integral PID unit with lagged difference.
// Depends on pwid_pkg, pwid_cell, pwid_regs and pwid_drive.
`timescale 1ns / 1ps

// One error sample is taken per clock cycle, back to back, while the result
// stream does not stall the pipeline. Three register stages (terms,
// products, sum) sit between a sample and its result word, which moves
// through them in that order. The unit keeps taking samples while a result
// waits, until the three pipeline stages are full. The error history is a
// line of WINDOW_LEN cells that shifts once per accepted sample; the oldest
// cell feeds the window sum update and a fixed tap DIFF_LAG cells back feeds
// the difference term. A lag that is a multiple of the window reads the
// oldest cell. Gains and the sum limit are written over APB at byte addresses
// 0, 4, 8 and 12, by the user only while the unit is idle; the unit does not
// enforce this. Reset clears the history and the sum.
module pid_windowed_integral_lagged_diff_unit #(
    parameter int WINDOW_LEN = pwid_pkg::DEF_WINDOW_LEN,
    parameter int DIFF_LAG   = pwid_pkg::DEF_DIFF_LAG
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] error_sample
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [28:0] drive_value, [31:29] zero
);

    localparam int LAG_MOD = DIFF_LAG % WINDOW_LEN;
    localparam int LAG_TAP = (LAG_MOD == 0) ? WINDOW_LEN - 1 : LAG_MOD - 1;
    localparam int RAW_W   = pwid_pkg::SUM_W + 2;

    pwid_pkg::gains_t                    gains;
    logic [pwid_pkg::LIMIT_W-1:0]        limit;
    logic signed [pwid_pkg::ERR_W-1:0]   hist [WINDOW_LEN];
    logic signed [pwid_pkg::ERR_W-1:0]   err;
    logic                                accept;
    logic signed [pwid_pkg::SUM_W-1:0]   window_sum_reg, window_sum_next;
    logic signed [RAW_W-1:0]             sum_raw, lim_pos, lim_neg, sum_clamped;
    pwid_pkg::terms_t                    terms;
    logic signed [pwid_pkg::DRIVE_W-1:0] drive;

    assign err    = s_tdata;
    assign accept = s_tvalid && s_tready;

    pwid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains),
        .limit   (limit)
    );

    // History line: cell 0 holds the latest sample, the last cell the oldest
    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
        if (k == 0) begin : g_head
            pwid_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (accept),
                .d_in     (err),
                .q_out    (hist[k])
            );
        end else begin : g_body
            pwid_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (accept),
                .d_in     (hist[k-1]),
                .q_out    (hist[k])
            );
        end
    end

    // Remove the leaving sample, add the new one, clamp to the limit
    always_comb begin
        lim_pos = RAW_W'({1'b0, limit});
        lim_neg = -lim_pos;
        sum_raw = RAW_W'(window_sum_reg) - RAW_W'(hist[WINDOW_LEN-1]) + RAW_W'(err);
        if (sum_raw > lim_pos) begin
            sum_clamped = lim_pos;
        end else if (sum_raw < lim_neg) begin
            sum_clamped = lim_neg;
        end else begin
            sum_clamped = sum_raw;
        end
        terms.err  = err;
        terms.sum  = pwid_pkg::SUM_W'(sum_clamped);
        terms.diff = pwid_pkg::DIFF_W'(err) - pwid_pkg::DIFF_W'(hist[LAG_TAP]);
        window_sum_next = accept ? terms.sum : window_sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_sum_reg <= '0;
        end else begin
            window_sum_reg <= window_sum_next;
        end
    end

    pwid_drive u_drive (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gains     (gains),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_terms  (terms),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_drive (drive)
    );

    assign m_tdata = {3'd0, drive};

    // Reset starts the window sum at zero
    assert property (@(posedge aclk) !aresetn |=> window_sum_reg == '0)
        else $error("window sum not cleared by reset");
    // The head cell takes the accepted word
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> hist[0] == $past(err))
        else $error("history head missed the accepted sample");
    // The stored sum stays within the limit it was clamped to
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (RAW_W'(window_sum_reg) <= $past(lim_pos))
                && (RAW_W'(window_sum_reg) >= $past(lim_neg)))
        else $error("window sum outside the integral limit");

endmodule

[dv/pwid_drive_checker.sv]
// Scoreboard for the windowed-integral PID unit: follows APB writes and both streams,
// predicts every drive word and compares it with the word the unit sends.
// Depends on pwid_pkg.
`timescale 1ns / 1ps

module pwid_drive_checker
    import pwid_pkg::*;
#(
    parameter int WINDOW_LEN = DEF_WINDOW_LEN,
    parameter int DIFF_LAG   = DEF_DIFF_LAG
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] error_sample
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [28:0] drive_value, [31:29] zero
    output int          pending_cnt,
    output int          fail_cnt
);

    // Controller settings as last written over APB
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIMIT_W-1:0]       sum_limit;

    // Error window and running sum
    logic signed [ERR_W-1:0]  err_ring [WINDOW_LEN];
    int unsigned              ring_pos;
    longint                   win_sum;

    // Drive words predicted but not yet seen on the result stream
    logic [DRIVE_W-1:0]       drive_q [$];
    int                       n_fail = 0;

    assign fail_cnt = n_fail;

    // Advance the window by one error sample and return the drive word it yields
    function automatic logic [DRIVE_W-1:0] step_controller(input logic signed [ERR_W-1:0] e);
        int unsigned slot;
        int unsigned back;
        longint      s;
        longint      diff;
        longint      total;
        longint      drv;
        slot = ring_pos;
        back = (slot + WINDOW_LEN - (DIFF_LAG % WINDOW_LEN)) % WINDOW_LEN;
        // remove the leaving sample, add the new one, clamp symmetrically
        s = win_sum - longint'(err_ring[slot]) + longint'(e);
        if (s > longint'(sum_limit)) begin
            s = longint'(sum_limit);
        end else if (s < -longint'(sum_limit)) begin
            s = -longint'(sum_limit);
        end
        win_sum = s;
        diff = longint'(e) - longint'(err_ring[back]);
        err_ring[slot] = e;
        ring_pos = (slot + 1) % WINDOW_LEN;
        // Q8.8 gains: floor the full sum by 256, then saturate
        total = longint'(kp) * longint'(e) + longint'(ki) * s + longint'(kd) * diff;
        drv = total >>> 8;
        if (drv > longint'(DRIVE_MAX)) begin
            drv = longint'(DRIVE_MAX);
        end else if (drv < -longint'(DRIVE_MAX)) begin
            drv = -longint'(DRIVE_MAX);
        end
        return drv[DRIVE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            kp        = '0;
            ki        = '0;
            kd        = '0;
            sum_limit = LIMIT_RESET;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                err_ring[i] = '0;
            end
            ring_pos = 0;
            win_sum  = 0;
            drive_q.delete();
        end else begin
            // Follow register writes
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_GAIN_P:  kp = pwdata[GAIN_W-1:0];
                    REG_GAIN_I:  ki = pwdata[GAIN_W-1:0];
                    REG_GAIN_D:  kd = pwdata[GAIN_W-1:0];
                    REG_I_LIMIT: sum_limit = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // Compare each result word with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    $error("drive_value: word with no sample pending, expected none, actual %0d",
                           $signed(m_tdata[DRIVE_W-1:0]));
                    n_fail++;
                end else begin
                    logic [DRIVE_W-1:0] want;
                    want = drive_q.pop_front();
                    if (m_tdata[DRIVE_W-1:0] !== want) begin
                        $error("drive_value mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(m_tdata[DRIVE_W-1:0]));
                        n_fail++;
                    end
                    if (m_tdata[31:DRIVE_W] !== '0) begin
                        $error("tdata pad mismatch: expected 0, actual %0d", m_tdata[31:DRIVE_W]);
                        n_fail++;
                    end
                end
            end
            // Predict the word for each accepted sample
            if (s_tvalid && s_tready) begin
                drive_q.push_back(step_controller(s_tdata[ERR_W-1:0]));
            end
        end
        pending_cnt <= drive_q.size();
    end

endmodule

[dv/tb_top.sv]
// Testbench top of the windowed-integral PID unit: clock, reset, APB writes,
// error samples and result backpressure. Depends on pwid_pkg, the unit and pwid_drive_checker.
`timescale 1ns / 1ps

module tb_top;
    import pwid_pkg::*;

    localparam int WIN         = DEF_WINDOW_LEN;
    localparam int LAG         = DEF_DIFF_LAG;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 135;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [ERR_W-1:0] CORNER_SAMPLES [9] = '{
        16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh0000,
        16'sh0001, -16'sh0001, 16'sh5555, -16'sh5556
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    logic        quiet_phase = 1'b0;
    int          rx_stall_left = 0;
    int unsigned cycle_cnt = 0;
    int          pending_cnt;
    int          fail_cnt;

    always #2 aclk = ~aclk;

    pid_windowed_integral_lagged_diff_unit #(
        .WINDOW_LEN (WIN),
        .DIFF_LAG   (LAG)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pwid_drive_checker #(
        .WINDOW_LEN (WIN),
        .DIFF_LAG   (LAG)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .pending_cnt (pending_cnt),
        .fail_cnt    (fail_cnt)
    );

    // Stall the result stream in short random bursts, never in the last phase
    always @(posedge aclk) begin
        if (rx_stall_left != 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Write one register: setup cycle, then access until pready
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one error sample, maybe after a random gap, and hold it until taken
    task automatic send_error(input logic signed [ERR_W-1:0] e);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= e;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every predicted word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_cnt != 0);
    endtask

    // Gain with a bias toward the extremes and unity
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'h0100;
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    initial begin
        logic signed [ERR_W-1:0] e;
        logic signed [ERR_W-1:0] last_e;
        logic [LIMIT_W-1:0]      lim;
        last_e = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: all gains zero, drive stays zero
        send_error(16'sh7FFF);
        send_error(-16'sh8000);

        // Moderate gains with a tight clamp on the sum
        wait_drained();
        write_reg(REG_GAIN_P, {16'($urandom()), 16'h0100});
        write_reg(REG_GAIN_I, {16'($urandom()), 16'h0010});
        write_reg(REG_GAIN_D, {16'($urandom()), 16'hFF00});
        write_reg(REG_I_LIMIT, {12'($urandom()), 20'd1000});
        foreach (CORNER_SAMPLES[i]) begin
            send_error(CORNER_SAMPLES[i]);
        end

        // Zero bound pins the sum at zero
        wait_drained();
        write_reg(REG_I_LIMIT, {12'($urandom()), 20'd0});
        send_error(16'sh7FFF);
        send_error(-16'sh0001);

        // Extreme gains, widest bound, sum driven hard negative
        wait_drained();
        write_reg(REG_GAIN_P, {16'($urandom()), 16'h8000});
        write_reg(REG_GAIN_I, {16'($urandom()), 16'h7FFF});
        write_reg(REG_GAIN_D, {16'($urandom()), 16'h8000});
        write_reg(REG_I_LIMIT, {12'($urandom()), 20'hFFFFF});
        repeat (10) send_error(-16'sh8000);

        // Random phases, each with fresh settings after a full drain
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            if (ph == N_PHASES - 1) begin
                quiet_phase <= 1'b1;
            end
            case ($urandom_range(0, 5))
                0:       lim = '0;
                1:       lim = 20'hFFFFF;
                2:       lim = LIMIT_RESET;
                3, 4:    lim = LIMIT_W'($urandom_range(1, 4000));
                default: lim = LIMIT_W'($urandom());
            endcase
            write_reg(REG_GAIN_P, {16'($urandom()), pick_gain()});
            write_reg(REG_GAIN_I, {16'($urandom()), pick_gain()});
            write_reg(REG_GAIN_D, {16'($urandom()), pick_gain()});
            write_reg(REG_I_LIMIT, {12'($urandom()), lim});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mix corners, repeated levels that push the sum into the clamp, and noise
                case ($urandom_range(0, 9))
                    0, 1: begin
                        case ($urandom_range(0, 3))
                            0:       e = 16'sh7FFF;
                            1:       e = -16'sh8000;
                            2:       e = 16'sh0000;
                            default: e = -16'sh0001;
                        endcase
                    end
                    2, 3, 4: e = last_e;
                    default: e = ERR_W'($urandom());
                endcase
                send_error(e);
                last_e = e;
            end
        end

        // Let the last words come out, then give the verdict
        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/pwid_pkg.sv
hw/rtl/pwid_cell.sv
hw/rtl/pwid_regs.sv
hw/rtl/pwid_drive.sv
hw/rtl/pid_windowed_integral_lagged_diff_unit.sv
dv/pwid_drive_checker.sv
dv/tb_top.sv
